@@ design/tswq_pkg.sv @@
// shared types and codes for the task slot and wait queue manager
// used by tswq_ctrl, tswq_datapath and the top level
`default_nettype none
package tswq_pkg;

  // default sizes
  localparam int DEF_NUM_SLOTS  = 16;
  localparam int DEF_NUM_QUEUES = 8;
  localparam int DEF_ID_BITS    = 16;

  // request codes
  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_QUERY  = 3'd2;
  localparam logic [2:0] CMD_WAIT   = 3'd3;
  localparam logic [2:0] CMD_SIGNAL = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_SLOT   = 2'd1;
  localparam logic [1:0] STS_BAD_STATE = 2'd2;

  // slot states
  localparam logic [1:0] SLOT_UNUSED   = 2'd0;
  localparam logic [1:0] SLOT_RUNNABLE = 2'd1;
  localparam logic [1:0] SLOT_WAITING  = 2'd2;

  // source of the slot table read address
  typedef enum logic [1:0] {
    SEL_PORT,
    SEL_REM,
    SEL_HEAD
  } sel_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic a_rd;
    logic q_rd;
    sel_t a_sel;
    logic mod_q;
    logic mod_r;
    logic exec;
    logic link;
    logic wake;
    logic res_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic port_query;
    logic wait_link;
    logic sig_wake;
  } sts_t;

endpackage
`default_nettype wire

@@ design/tswq_datapath.sv @@
// slot and queue tables, free list head, id modulo unit and result registers
// depends on tswq_pkg; sequenced by tswq_ctrl
`default_nettype none
module tswq_datapath #(
  parameter int NUM_SLOTS  = tswq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_QUEUES = tswq_pkg::DEF_NUM_QUEUES,
  parameter int ID_BITS    = tswq_pkg::DEF_ID_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tswq_pkg::ctl_t  ctl,
  output tswq_pkg::sts_t       sts,
  input  wire logic [2:0]      command,
  input  wire logic [3:0]      slot_index,
  input  wire logic [15:0]     task_id_in,
  input  wire logic [2:0]      queue_id,
  output logic [1:0]           status,
  output logic [15:0]          task_id_out,
  output logic [3:0]           slot_out,
  output logic                 woke,
  output logic                 blocked,
  output logic                 terminated
);

  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int LW  = $clog2(NUM_SLOTS + 1);
  localparam int RW  = SW + 1;
  localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int AWW = ID_BITS + 2;
  localparam int QWW = 2 * LW + 16;
  localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);
  localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / NUM_SLOTS);

  // tables
  logic [AWW-1:0] mem_a [NUM_SLOTS];
  logic [LW-1:0]  mem_l [NUM_SLOTS];
  logic [QWW-1:0] mem_q [NUM_QUEUES];
  logic [NUM_SLOTS-1:0]  slot_valid;
  logic [NUM_QUEUES-1:0] queue_valid;

  // latched request
  logic [2:0]         cmd_r;
  logic [3:0]         slot_r;
  logic [ID_BITS-1:0] tid_r;
  logic [2:0]         qid_r;

  logic [LW-1:0]  free_head;
  logic [LW-1:0]  free_head_next;
  logic           fh_we;

  // registered read data
  logic [AWW-1:0] a_rdata;
  logic [LW-1:0]  l_rdata;
  logic           a_rvalid;
  logic [SW-1:0]  a_raddr;
  logic [QWW-1:0] q_rdata;
  logic           q_rvalid;

  // modulo unit
  logic [15:0]    quot;
  logic [RW-1:0]  rem;
  logic [15:0]    x16;
  logic [47:0]    prod;
  logic [15:0]    qn;
  logic [15:0]    rem_wide;
  logic [RW-1:0]  rem_fix;

  logic [SW-1:0]  a_addr;
  logic [QAW-1:0] q_addr;

  // effective entries, with reset values for entries never written
  logic [1:0]         st_eff;
  logic [ID_BITS-1:0] id_eff;
  logic [LW-1:0]      l_eff;
  logic [LW-1:0]      q_head;
  logic [LW-1:0]      q_tail;
  logic [15:0]        q_pend;

  logic slot_in_range, q_in_range, fh_empty, slot_run;
  logic wait_ok, wait_block, tail_empty;

  logic           a_we;
  logic [SW-1:0]  a_waddr;
  logic [AWW-1:0] a_wdata;
  logic           l_we;
  logic [SW-1:0]  l_waddr;
  logic [LW-1:0]  l_wdata;
  logic           q_we;
  logic [QWW-1:0] q_wdata;

  logic [1:0]  status_next;
  logic [15:0] task_id_out_next;
  logic [3:0]  slot_out_next;
  logic        woke_next, blocked_next, terminated_next;

  assign x16      = 16'(tid_r);
  assign prod     = x16 * MOD_RECIP;
  assign qn       = 16'(quot * 16'(NUM_SLOTS));
  assign rem_wide = x16 - qn;
  // quotient estimate is low by at most one
  assign rem_fix  = (rem >= RW'(NUM_SLOTS)) ? rem - RW'(NUM_SLOTS) : rem;

  assign q_addr = QAW'(queue_id);

  always_comb begin
    unique case (ctl.a_sel)
      tswq_pkg::SEL_PORT: begin
        a_addr = (command == tswq_pkg::CMD_ALLOC) ? free_head[SW-1:0] : SW'(slot_index);
      end
      tswq_pkg::SEL_REM:  a_addr = rem_fix[SW-1:0];
      tswq_pkg::SEL_HEAD: a_addr = q_head[SW-1:0];
      default:            a_addr = SW'(slot_index);
    endcase
  end

  always_comb begin
    if (a_rvalid) begin
      st_eff = a_rdata[AWW-1:ID_BITS];
      id_eff = a_rdata[ID_BITS-1:0];
      l_eff  = l_rdata;
    end else begin
      st_eff = tswq_pkg::SLOT_UNUSED;
      id_eff = ID_BITS'(a_raddr);
      l_eff  = LW'(a_raddr) + LW'(1);
    end
    if (q_rvalid) begin
      q_head = q_rdata[QWW-1:LW+16];
      q_tail = q_rdata[LW+15:16];
      q_pend = q_rdata[15:0];
    end else begin
      q_head = NIL;
      q_tail = NIL;
      q_pend = 16'd0;
    end
  end

  assign slot_in_range = 9'(slot_r) < 9'(NUM_SLOTS);
  assign q_in_range    = 7'(qid_r) < 7'(NUM_QUEUES);
  assign fh_empty      = free_head >= NIL;
  assign slot_run      = slot_in_range && (st_eff == tswq_pkg::SLOT_RUNNABLE);
  assign wait_ok       = q_in_range && slot_run;
  assign wait_block    = wait_ok && (q_pend == 16'd0);
  assign tail_empty    = q_tail >= NIL;

  assign sts.port_query = (command == tswq_pkg::CMD_QUERY);
  assign sts.wait_link  = (cmd_r == tswq_pkg::CMD_WAIT) && wait_block && !tail_empty;
  assign sts.sig_wake   = (cmd_r == tswq_pkg::CMD_SIGNAL) && q_in_range && (q_head < NIL);

  // table updates
  always_comb begin
    a_we           = 1'b0;
    a_waddr        = SW'(slot_r);
    a_wdata        = {st_eff, id_eff};
    l_we           = 1'b0;
    l_waddr        = SW'(slot_r);
    l_wdata        = NIL;
    q_we           = 1'b0;
    q_wdata        = {q_head, q_tail, q_pend};
    fh_we          = 1'b0;
    free_head_next = free_head;
    if (ctl.wake) begin
      a_we    = 1'b1;
      a_waddr = a_raddr;
      a_wdata = {tswq_pkg::SLOT_RUNNABLE, id_eff};
      l_we    = 1'b1;
      l_waddr = a_raddr;
      q_we    = 1'b1;
      if (l_eff < NIL) begin
        q_wdata = {l_eff, q_tail, q_pend};
      end else begin
        q_wdata = {NIL, NIL, q_pend};
      end
    end else if (ctl.link) begin
      l_we    = 1'b1;
      l_waddr = q_tail[SW-1:0];
      l_wdata = LW'(slot_r);
    end else if (ctl.exec) begin
      case (cmd_r)
        tswq_pkg::CMD_ALLOC: begin
          if (!fh_empty) begin
            a_we           = 1'b1;
            a_waddr        = free_head[SW-1:0];
            a_wdata        = {tswq_pkg::SLOT_RUNNABLE, id_eff + ID_BITS'(NUM_SLOTS)};
            l_we           = 1'b1;
            l_waddr        = free_head[SW-1:0];
            fh_we          = 1'b1;
            free_head_next = l_eff;
          end
        end
        tswq_pkg::CMD_FREE: begin
          if (slot_run) begin
            a_we           = 1'b1;
            a_wdata        = {tswq_pkg::SLOT_UNUSED, id_eff};
            l_we           = 1'b1;
            l_wdata        = free_head;
            fh_we          = 1'b1;
            free_head_next = LW'(slot_r);
          end
        end
        tswq_pkg::CMD_WAIT: begin
          if (wait_ok && !wait_block) begin
            q_we    = 1'b1;
            q_wdata = {q_head, q_tail, q_pend - 16'd1};
          end else if (wait_block) begin
            a_we    = 1'b1;
            a_wdata = {tswq_pkg::SLOT_WAITING, id_eff};
            l_we    = 1'b1;
            q_we    = 1'b1;
            q_wdata = {(tail_empty ? LW'(slot_r) : q_head), LW'(slot_r), q_pend};
          end
        end
        tswq_pkg::CMD_SIGNAL: begin
          // saturating count when nobody waits
          if (q_in_range && !(q_head < NIL) && (q_pend != 16'hFFFF)) begin
            q_we    = 1'b1;
            q_wdata = {q_head, q_tail, q_pend + 16'd1};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the request
  always_comb begin
    status_next      = tswq_pkg::STS_OK;
    task_id_out_next = 16'd0;
    slot_out_next    = 4'd0;
    woke_next        = 1'b0;
    blocked_next     = 1'b0;
    terminated_next  = 1'b0;
    if (ctl.wake) begin
      slot_out_next = 4'(a_raddr);
      woke_next     = 1'b1;
    end else begin
      case (cmd_r)
        tswq_pkg::CMD_ALLOC: begin
          if (fh_empty) begin
            status_next = tswq_pkg::STS_NO_SLOT;
          end else begin
            task_id_out_next = 16'(id_eff + ID_BITS'(NUM_SLOTS));
            slot_out_next    = 4'(free_head[SW-1:0]);
          end
        end
        tswq_pkg::CMD_FREE: begin
          if (!slot_run) status_next = tswq_pkg::STS_BAD_STATE;
        end
        tswq_pkg::CMD_QUERY: begin
          terminated_next = (st_eff == tswq_pkg::SLOT_UNUSED) || (id_eff != tid_r);
        end
        tswq_pkg::CMD_WAIT: begin
          if (!wait_ok) status_next = tswq_pkg::STS_BAD_STATE;
          blocked_next = wait_block;
        end
        tswq_pkg::CMD_SIGNAL: begin
          if (!q_in_range) status_next = tswq_pkg::STS_BAD_STATE;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      slot_valid  <= '0;
      queue_valid <= '0;
    end else begin
      if (fh_we) free_head <= free_head_next;
      if (a_we) slot_valid[a_waddr] <= 1'b1;
      if (l_we) slot_valid[l_waddr] <= 1'b1;
      if (q_we) queue_valid[QAW'(qid_r)] <= 1'b1;
    end
  end

  // tables and read registers
  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (l_we) mem_l[l_waddr] <= l_wdata;
    if (q_we) mem_q[QAW'(qid_r)] <= q_wdata;
    if (ctl.a_rd) begin
      a_rdata  <= mem_a[a_addr];
      l_rdata  <= mem_l[a_addr];
      a_rvalid <= slot_valid[a_addr];
      a_raddr  <= a_addr;
    end
    if (ctl.q_rd) begin
      q_rdata  <= mem_q[q_addr];
      q_rvalid <= queue_valid[q_addr];
    end
  end

  // request latch, modulo unit and results
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= command;
      slot_r <= slot_index;
      tid_r  <= ID_BITS'(task_id_in);
      qid_r  <= queue_id;
    end
    if (ctl.mod_q) quot <= prod[47:32];
    if (ctl.mod_r) rem <= RW'(rem_wide);
    if (ctl.res_load) begin
      status      <= status_next;
      task_id_out <= task_id_out_next;
      slot_out    <= slot_out_next;
      woke        <= woke_next;
      blocked     <= blocked_next;
      terminated  <= terminated_next;
    end
  end

endmodule
`default_nettype wire

@@ design/tswq_ctrl.sv @@
// sequencing state machine for the task slot and wait queue manager
// depends on tswq_pkg; drives tswq_datapath
`default_nettype none
module tswq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire tswq_pkg::sts_t  sts,
  output tswq_pkg::ctl_t       ctl,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_Q,
    S_MOD_R,
    S_RD,
    S_EXEC,
    S_LINK,
    S_WAKE
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.a_sel = tswq_pkg::SEL_PORT;
    unique case (state)
      S_IDLE: begin
        ctl.load = start;
        ctl.a_rd = start;
        ctl.q_rd = start;
      end
      S_MOD_Q: ctl.mod_q = 1'b1;
      S_MOD_R: ctl.mod_r = 1'b1;
      S_RD: begin
        ctl.a_rd  = 1'b1;
        ctl.a_sel = tswq_pkg::SEL_REM;
      end
      S_EXEC: begin
        ctl.exec     = 1'b1;
        ctl.res_load = !sts.sig_wake;
        // fetch the head waiter's entry
        if (sts.sig_wake) begin
          ctl.a_rd  = 1'b1;
          ctl.a_sel = tswq_pkg::SEL_HEAD;
        end
      end
      S_LINK: ctl.link = 1'b1;
      S_WAKE: begin
        ctl.wake     = 1'b1;
        ctl.res_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= sts.port_query ? S_MOD_Q : S_EXEC;
        end
        S_MOD_Q: state <= S_MOD_R;
        S_MOD_R: state <= S_RD;
        S_RD:    state <= S_EXEC;
        S_EXEC: begin
          if (sts.wait_link) begin
            state <= S_LINK;
          end else if (sts.sig_wake) begin
            state <= S_WAKE;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_LINK, S_WAKE: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/task_slot_and_wait_queue_manager.sv @@
// task slot pool and counting wait queues, one request at a time
// path from accept to done: alloc, free, signal without waiter, a wait that
// consumes a signal or is rejected, and unknown codes pass only the execute
// state; a wait blocking behind a waiter adds a tail link write, a waking signal
// a second slot table read, query the two-step id modulo unit then a table read;
// busy drops with done; reset is synchronous; tables read as reset values via
// per-entry valid bits, so requests are taken from the first cycle after reset
`default_nettype none
module task_slot_and_wait_queue_manager #(
  parameter int NUM_SLOTS  = tswq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_QUEUES = tswq_pkg::DEF_NUM_QUEUES,
  parameter int ID_BITS    = tswq_pkg::DEF_ID_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [2:0]  command,
  input  wire logic [3:0]  slot_index,
  input  wire logic [15:0] task_id_in,
  input  wire logic [2:0]  queue_id,
  output logic [1:0]       status,
  output logic [15:0]      task_id_out,
  output logic [3:0]       slot_out,
  output logic             woke,
  output logic             blocked,
  output logic             terminated
);

  tswq_pkg::ctl_t ctl;
  tswq_pkg::sts_t sts;

  tswq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  tswq_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .slot_index  (slot_index),
    .task_id_in  (task_id_in),
    .queue_id    (queue_id),
    .status      (status),
    .task_id_out (task_id_out),
    .slot_out    (slot_out),
    .woke        (woke),
    .blocked     (blocked),
    .terminated  (terminated)
  );

endmodule
`default_nettype wire

@@ test/tswq_call_checker.sv @@
// reply checker for the task slot and wait queue manager: follows every accepted
// request, predicts its reply from a private copy of the slot and queue tables
// and compares it with the next done strobe; codes come from tswq_pkg
module tswq_call_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        done,
  input  wire logic [2:0]  command,
  input  wire logic [3:0]  slot_index,
  input  wire logic [15:0] task_id_in,
  input  wire logic [2:0]  queue_id,
  input  wire logic [1:0]  status,
  input  wire logic [15:0] task_id_out,
  input  wire logic [3:0]  slot_out,
  input  wire logic        woke,
  input  wire logic        blocked,
  input  wire logic        terminated,
  output int               errors,
  output int               outstanding
);

  localparam int SLOTS = tswq_pkg::DEF_NUM_SLOTS;
  localparam int QUEUES = tswq_pkg::DEF_NUM_QUEUES;
  localparam logic [4:0] NO_SLOT = 5'(SLOTS);
  localparam logic [15:0] SIGNAL_CEILING = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] task_id;
    logic [3:0]  slot;
    logic        woke;
    logic        blocked;
    logic        terminated;
  } reply_t;

  logic [1:0]  slot_state [SLOTS];
  logic [15:0] slot_tid [SLOTS];
  logic [4:0]  slot_next [SLOTS];
  logic [4:0]  free_top;
  logic [4:0]  wq_first [QUEUES];
  logic [4:0]  wq_last [QUEUES];
  logic [15:0] wq_signals [QUEUES];

  reply_t replies_due [$];
  int fail_tally = 0;

  task automatic reset_tables();
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = tswq_pkg::SLOT_UNUSED;
      slot_tid[i] = 16'(i);
      slot_next[i] = 5'(i + 1);
    end
    free_top = '0;
    for (int q = 0; q < QUEUES; q++) begin
      wq_first[q] = NO_SLOT;
      wq_last[q] = NO_SLOT;
      wq_signals[q] = '0;
    end
  endtask

  // applies one request to the tables and returns the reply it must produce
  function automatic reply_t compute_reply(input logic [2:0] cmd, input logic [3:0] slot,
                                           input logic [15:0] tid, input logic [2:0] q);
    reply_t r;
    logic [3:0] s;
    r = '0;
    case (cmd)
      tswq_pkg::CMD_ALLOC: begin
        if (free_top >= NO_SLOT) begin
          r.status = tswq_pkg::STS_NO_SLOT;
        end else begin
          s = free_top[3:0];
          free_top = slot_next[s];
          slot_next[s] = NO_SLOT;
          slot_state[s] = tswq_pkg::SLOT_RUNNABLE;
          slot_tid[s] = slot_tid[s] + 16'(SLOTS);
          r.task_id = slot_tid[s];
          r.slot = s;
        end
      end
      tswq_pkg::CMD_FREE: begin
        if (slot_state[slot] != tswq_pkg::SLOT_RUNNABLE) begin
          r.status = tswq_pkg::STS_BAD_STATE;
        end else begin
          slot_state[slot] = tswq_pkg::SLOT_UNUSED;
          slot_next[slot] = free_top;
          free_top = {1'b0, slot};
        end
      end
      tswq_pkg::CMD_QUERY: begin
        s = tid[3:0];
        r.terminated = (slot_state[s] == tswq_pkg::SLOT_UNUSED) || (slot_tid[s] != tid);
      end
      tswq_pkg::CMD_WAIT: begin
        if (slot_state[slot] != tswq_pkg::SLOT_RUNNABLE) begin
          r.status = tswq_pkg::STS_BAD_STATE;
        end else if (wq_signals[q] != 0) begin
          wq_signals[q] = wq_signals[q] - 16'd1;
        end else begin
          slot_state[slot] = tswq_pkg::SLOT_WAITING;
          slot_next[slot] = NO_SLOT;
          if (wq_last[q] >= NO_SLOT) wq_first[q] = {1'b0, slot};
          else slot_next[wq_last[q][3:0]] = {1'b0, slot};
          wq_last[q] = {1'b0, slot};
          r.blocked = 1'b1;
        end
      end
      tswq_pkg::CMD_SIGNAL: begin
        if (wq_first[q] < NO_SLOT) begin
          s = wq_first[q][3:0];
          wq_first[q] = slot_next[s];
          if (wq_first[q] >= NO_SLOT) begin
            wq_first[q] = NO_SLOT;
            wq_last[q] = NO_SLOT;
          end
          slot_state[s] = tswq_pkg::SLOT_RUNNABLE;
          slot_next[s] = NO_SLOT;
          r.slot = s;
          r.woke = 1'b1;
        end else if (wq_signals[q] != SIGNAL_CEILING) begin
          wq_signals[q] = wq_signals[q] + 16'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_tally++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      reset_tables();
      replies_due.delete();
    end else begin
      // compare before taking a new request so a stray strobe is not hidden
      if (done) begin
        if (replies_due.size() == 0) begin
          fail_tally++;
          $error("done strobe with no request outstanding");
        end else begin
          want = replies_due.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("task_id_out", want.task_id, task_id_out);
          check_field("slot_out", 16'(want.slot), 16'(slot_out));
          check_field("woke", 16'(want.woke), 16'(woke));
          check_field("blocked", 16'(want.blocked), 16'(blocked));
          check_field("terminated", 16'(want.terminated), 16'(terminated));
        end
      end
      if (start && !busy)
        replies_due.push_back(compute_reply(command, slot_index, task_id_in, queue_id));
    end
    errors <= fail_tally;
    outstanding <= replies_due.size();
  end

endmodule

@@ test/task_slot_and_wait_queue_manager_tb.sv @@
// testbench top for the task slot and wait queue manager: drives requests with
// random spacing, leaves prediction and comparison to tswq_call_checker and
// gives the verdict; needs tswq_pkg and the block itself
module task_slot_and_wait_queue_manager_tb;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_CALLS = 1550;
  localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] CMD_LAST_UNKNOWN = 3'd7;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  logic [2:0]  command;
  logic [3:0]  slot_index;
  logic [15:0] task_id_in;
  logic [2:0]  queue_id;
  logic [1:0]  status;
  logic [15:0] task_id_out;
  logic [3:0]  slot_out;
  logic        woke;
  logic        blocked;
  logic        terminated;
  int          errors;
  int          outstanding;

  // last id handed out per slot, used to aim queries at live and stale tasks
  logic [15:0] known_id [tswq_pkg::DEF_NUM_SLOTS];

  task_slot_and_wait_queue_manager dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .command(command), .slot_index(slot_index), .task_id_in(task_id_in),
    .queue_id(queue_id), .status(status), .task_id_out(task_id_out),
    .slot_out(slot_out), .woke(woke), .blocked(blocked), .terminated(terminated)
  );

  tswq_call_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .command(command), .slot_index(slot_index), .task_id_in(task_id_in),
    .queue_id(queue_id), .status(status), .task_id_out(task_id_out),
    .slot_out(slot_out), .woke(woke), .blocked(blocked), .terminated(terminated),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tswq_pkg::DEF_NUM_SLOTS; i++) known_id[i] <= 16'(i);
    end else if (done && status == tswq_pkg::STS_OK && task_id_out != 0) begin
      known_id[slot_out] <= task_id_out;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input logic [2:0] cmd, input logic [3:0] slot, input logic [15:0] tid,
                       input logic [2:0] q, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command <= cmd;
    slot_index <= slot;
    task_id_in <= tid;
    queue_id <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_call(input int gap);
    int pick;
    logic [2:0] cmd;
    logic [3:0] s;
    logic [15:0] tid;
    logic [2:0] q;
    pick = $urandom_range(0, 99);
    s = 4'($urandom_range(0, 15));
    tid = 16'($urandom());
    // most traffic on a few queues so waiter lists grow long
    q = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 7));
    if (pick < 20) cmd = tswq_pkg::CMD_ALLOC;
    else if (pick < 35) cmd = tswq_pkg::CMD_FREE;
    else if (pick < 50) cmd = tswq_pkg::CMD_QUERY;
    else if (pick < 75) cmd = tswq_pkg::CMD_WAIT;
    else if (pick < 96) cmd = tswq_pkg::CMD_SIGNAL;
    else cmd = 3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
    if (cmd == tswq_pkg::CMD_QUERY) begin
      case ($urandom_range(0, 3))
        0: ;
        1: tid = known_id[s];
        2: tid = known_id[s] - 16'(tswq_pkg::DEF_NUM_SLOTS);
        default: tid = known_id[s] + 16'(tswq_pkg::DEF_NUM_SLOTS);
      endcase
    end
    issue(cmd, s, tid, q, gap);
  endtask

  initial begin : stimulus
    bit quiet;
    rst = 1'b1;
    start = 1'b0;
    command = tswq_pkg::CMD_ALLOC;
    slot_index = '0;
    task_id_in = '0;
    queue_id = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the pool, the last alloc finds it empty
    repeat (tswq_pkg::DEF_NUM_SLOTS + 1)
      issue(tswq_pkg::CMD_ALLOC, 4'($urandom()), 16'($urandom()), 3'($urandom()),
            $urandom_range(0, 7));
    issue(tswq_pkg::CMD_QUERY, 4'd0, known_id[3], 3'd0, 1);
    issue(tswq_pkg::CMD_QUERY, 4'd0, 16'd3, 3'd0, 0);
    issue(tswq_pkg::CMD_QUERY, 4'hF, 16'hFFFF, 3'd7, 2);
    issue(tswq_pkg::CMD_QUERY, 4'd0, 16'd0, 3'd0, 0);
    issue(tswq_pkg::CMD_WAIT, 4'd1, 16'd0, 3'd0, 0);
    issue(tswq_pkg::CMD_WAIT, 4'd1, 16'd0, 3'd0, 4);
    issue(tswq_pkg::CMD_FREE, 4'd1, 16'd0, 3'd0, 0);
    issue(tswq_pkg::CMD_SIGNAL, 4'd0, 16'd0, 3'd0, 7);
    issue(tswq_pkg::CMD_SIGNAL, 4'd0, 16'd0, 3'd0, 0);
    issue(tswq_pkg::CMD_WAIT, 4'd2, 16'd0, 3'd0, 1);
    issue(tswq_pkg::CMD_FREE, 4'd2, 16'd0, 3'd0, 0);
    issue(tswq_pkg::CMD_FREE, 4'd2, 16'd0, 3'd0, 0);
    issue(tswq_pkg::CMD_WAIT, 4'd2, 16'd0, 3'd1, 5);
    issue(CMD_FIRST_UNKNOWN, 4'd0, 16'd0, 3'd0, 0);
    issue(CMD_LAST_UNKNOWN, 4'hF, 16'hFFFF, 3'd7, 2);

    for (int i = 0; i < RANDOM_CALLS; i++) begin
      // now and then a stretch of back-to-back requests
      if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      random_call(quiet ? 0 : $urandom_range(0, 7));
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("FAIL");
    $finish;
  end

endmodule

@@ task_slot_and_wait_queue_manager.f @@
design/tswq_pkg.sv
design/tswq_datapath.sv
design/tswq_ctrl.sv
design/task_slot_and_wait_queue_manager.sv
test/tswq_call_checker.sv
test/task_slot_and_wait_queue_manager_tb.sv
